@@ rtl/core/itbt_pkg.sv @@
// ----------------------------------------------------------------------------
// itbt_pkg
// Shared constants, codes and types of the image block transfer tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package itbt_pkg;

  // bitmap geometry
  localparam int BITMAP_BYTES = 32;
  localparam int BM_AW        = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int MAX_BLOCKS   = BITMAP_BYTES * 8;
  localparam int BLK_W        = $clog2(MAX_BLOCKS + 1);
  localparam int BM_LEN_W     = $clog2(BITMAP_BYTES + 1);
  localparam int MAX_ID_LEN   = 32;

  // field widths
  localparam int ACT_W    = 3;
  localparam int WORD_W   = 32;
  localparam int IDLEN_W  = 8;
  localparam int RC_W     = 2;
  localparam int STATUS_W = 3;
  localparam int BYTE_W   = 8;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSFER_ENABLED = 1'd1;
  localparam logic [WORD_W-1:0]    BLOCK_SIZE_RST       = 32'd50;

  // mask of block zero within a bitmap byte
  localparam logic [BYTE_W-1:0] BIT0_MASK = 8'h80;

  // command codes
  localparam logic [ACT_W-1:0] ACT_BLOCK    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INIT     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_START    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_STOP     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_VERIFY   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_ACTIVATE = 3'd5;

  // result codes
  localparam logic [RC_W-1:0] RC_OK       = 2'd0;
  localparam logic [RC_W-1:0] RC_TEMP     = 2'd1;
  localparam logic [RC_W-1:0] RC_BAD_ENC  = 2'd2;
  localparam logic [RC_W-1:0] RC_UNAUTH   = 2'd3;

  // transfer status codes
  localparam logic [STATUS_W-1:0] ST_IDLE       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INITIATED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INIT_OK    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INIT_ERR   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_VERIFY_OK  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_VERIFY_ERR = 3'd5;
  localparam logic [STATUS_W-1:0] ST_ACT_OK     = 3'd6;
  localparam logic [STATUS_W-1:0] ST_ACT_ERR    = 3'd7;

  // divider
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } itbt_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } itbt_div_res_t;

endpackage

`default_nettype wire

@@ rtl/core/itbt_if.sv @@
// ----------------------------------------------------------------------------
// itbt_if
// Command and result channels of the tracker, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface itbt_cmd_if;
  import itbt_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic                encoding_ok;
  logic [WORD_W-1:0]   blk_index;
  logic [WORD_W-1:0]   blk_len;
  logic [WORD_W-1:0]   img_size;
  logic [IDLEN_W-1:0]  id_len;

  modport source (
    output valid, action, encoding_ok, blk_index, blk_len, img_size,
           id_len,
    input  ready
  );

  modport sink (
    input  valid, action, encoding_ok, blk_index, blk_len, img_size,
           id_len,
    output ready
  );
endinterface

interface itbt_res_if;
  import itbt_pkg::*;

  logic                valid;
  logic                ready;
  logic [RC_W-1:0]     result_code;
  logic [STATUS_W-1:0] xfer_state;
  logic [BLK_W-1:0]    blk_received;
  logic [BLK_W-1:0]    first_missing_block;
  logic [BM_LEN_W-1:0] bitmap_bytes;

  modport source (
    output valid, result_code, xfer_state, blk_received,
           first_missing_block, bitmap_bytes,
    input  ready
  );

  modport sink (
    input  valid, result_code, xfer_state, blk_received,
           first_missing_block, bitmap_bytes,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/image_block_transfer_tracker_core.sv @@
// ----------------------------------------------------------------------------
// image_block_transfer_tracker_core
// Sequence: start, stop, verify, activate and rejected commands have their
//   result registered from the done state; init runs the divide, then a
//   32-entry bitmap clear that is skipped when the bitmap would not fit;
//   a block writes its bit, then fetches and searches bitmap bytes for the
//   first missing block, skipped when every block is already in. One command
//   at a time: the next one is taken the cycle after the result is registered.
// Reset: status idle, counts and geometry zero; the bitmap RAM is not swept
//   at reset, it is cleared by every successful init.
// ----------------------------------------------------------------------------
`default_nettype none

module image_block_transfer_tracker_core (
  input  logic                             clk,
  input  logic                             rst,
  itbt_cmd_if.sink                         cmd,
  itbt_res_if.source                       res,
  input  logic                             cfg_wen,
  input  logic [itbt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [itbt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import itbt_pkg::*;

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE = 3'd0;
  localparam logic [ST_W-1:0] S_EXEC = 3'd1;
  localparam logic [ST_W-1:0] S_DIV  = 3'd2;
  localparam logic [ST_W-1:0] S_CLR  = 3'd3;
  localparam logic [ST_W-1:0] S_BCHK = 3'd4;
  localparam logic [ST_W-1:0] S_SCAN = 3'd5;
  localparam logic [ST_W-1:0] S_SCHK = 3'd6;
  localparam logic [ST_W-1:0] S_DONE = 3'd7;

  // configuration registers
  logic [WORD_W-1:0]   blk_bytes;
  logic                xfer_allowed;

  // tracker state
  logic [ST_W-1:0]     state;
  logic [STATUS_W-1:0] status_reg;
  logic [BM_LEN_W-1:0] bitmap_len;
  logic [BLK_W-1:0]    received_count;
  logic [BLK_W-1:0]    first_missing;
  logic [BLK_W-1:0]    total_blocks;
  logic [WORD_W-1:0]   last_block_len;
  logic [BM_AW-1:0]    clr_addr;
  logic [RC_W-1:0]     rc_q;

  // latched command word
  logic [ACT_W-1:0]    act_q;
  logic                enc_q;
  logic [WORD_W-1:0]   num_q;
  logic [WORD_W-1:0]   len_q;
  logic [WORD_W-1:0]   size_q;
  logic [IDLEN_W-1:0]  idlen_q;

  // result register
  logic                res_valid;
  logic [RC_W-1:0]     res_rc;
  logic [STATUS_W-1:0] res_status;
  logic [BLK_W-1:0]    res_count;
  logic [BLK_W-1:0]    res_missing;
  logic [BM_LEN_W-1:0] res_bm_len;

  // bitmap ram
  logic                ram_we;
  logic [BM_AW-1:0]    ram_waddr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic [BM_AW-1:0]    ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;

  itbt_div_req_t       div_req;
  itbt_div_res_t       div_res;

  // decode helpers
  logic                blk_status_ok;
  logic                blk_in_range;
  logic                blk_is_last;
  logic [WORD_W-1:0]   blk_limit;
  logic                blk_len_bad;
  logic [BYTE_W-1:0]   sel_mask;
  logic                bit_hit;
  logic                init_bad;
  logic                verify_bad;
  logic [DIV_W:0]      blk_count;
  logic                count_too_big;
  logic [BLK_W:0]      bytes_sum;
  logic [WORD_W-1:0]   last_len_calc;
  logic                scan_found;
  logic [2:0]          scan_pos;
  logic [BLK_W-1:0]    scan_next;

  itbt_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BITMAP_BYTES)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  itbt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_bytes    <= BLOCK_SIZE_RST;
      xfer_allowed <= 1'b1;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_BLOCK_SIZE:       blk_bytes    <= cfg_data;
        REG_TRANSFER_ENABLED: xfer_allowed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // block transfer checks
  assign blk_status_ok = (status_reg == ST_INIT_OK) || (status_reg == ST_INITIATED);
  assign blk_in_range  = (total_blocks != '0) && (num_q < WORD_W'(total_blocks));
  assign blk_is_last   = (num_q == WORD_W'(total_blocks) - 1'b1);
  assign blk_limit     = blk_is_last ? last_block_len : blk_bytes;
  assign blk_len_bad   = (len_q == '0) || (len_q > blk_limit);
  assign sel_mask      = BIT0_MASK >> num_q[2:0];
  assign bit_hit       = |(ram_rdata & sel_mask);

  // init and verify checks
  assign init_bad   = !enc_q || (idlen_q > IDLEN_W'(MAX_ID_LEN)) || (blk_bytes == '0);
  assign verify_bad = (status_reg != ST_INITIATED) || (total_blocks == '0) ||
                      (received_count < total_blocks) || (first_missing < total_blocks);

  // block count as quotient rounded up
  assign blk_count     = {1'b0, div_res.quo} + (DIV_W + 1)'(div_res.rem != '0);
  assign count_too_big = blk_count > (DIV_W + 1)'(MAX_BLOCKS);
  assign bytes_sum     = {1'b0, blk_count[BLK_W-1:0]} + (BLK_W + 1)'(7);
  assign last_len_calc = (size_q == '0) ? '0 :
                         (div_res.rem != '0) ? div_res.rem : blk_bytes;

  // first clear bit at or above the scan point within the fetched byte
  always_comb begin
    scan_found = 1'b0;
    scan_pos   = '0;
    for (int j = 0; j < BYTE_W; j++) begin
      if (!scan_found && (3'(j) >= first_missing[2:0]) && !ram_rdata[3'(BYTE_W - 1 - j)]) begin
        scan_found = 1'b1;
        scan_pos   = 3'(j);
      end
    end
  end

  assign scan_next = scan_found ? {first_missing[BLK_W-1:3], scan_pos}
                                : {first_missing[BLK_W-1:3] + 1'b1, 3'b000};

  // divider launch
  assign div_req.start    = (state == S_EXEC) && (act_q == ACT_INIT) &&
                            xfer_allowed && !init_bad;
  assign div_req.dividend = size_q;
  assign div_req.divisor  = blk_bytes;

  // bitmap ram access: clear sweep, set-bit write, scan fetch
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = num_q[BM_AW+2:3];
    ram_wdata = ram_rdata | sel_mask;
    ram_raddr = num_q[BM_AW+2:3];
    unique case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_BCHK: begin
        ram_we = !bit_hit;
      end
      S_SCAN: begin
        ram_raddr = first_missing[BM_AW+2:3];
      end
      default: ;
    endcase
  end

  // command word capture
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      act_q   <= cmd.action;
      enc_q   <= cmd.encoding_ok;
      num_q   <= cmd.blk_index;
      len_q   <= cmd.blk_len;
      size_q  <= cmd.img_size;
      idlen_q <= cmd.id_len;
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      status_reg     <= ST_IDLE;
      bitmap_len     <= '0;
      received_count <= '0;
      first_missing  <= '0;
      total_blocks   <= '0;
      last_block_len <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (act_q)
            ACT_BLOCK: begin
              if (!blk_status_ok) begin
                rc_q  <= RC_TEMP;
                state <= S_DONE;
              end else if (!enc_q || !blk_in_range || blk_len_bad) begin
                rc_q  <= RC_BAD_ENC;
                state <= S_DONE;
              end else begin
                rc_q  <= RC_OK;
                state <= S_BCHK;
              end
            end
            ACT_INIT: begin
              if (!xfer_allowed) begin
                rc_q  <= RC_UNAUTH;
                state <= S_DONE;
              end else if (init_bad) begin
                rc_q       <= RC_BAD_ENC;
                status_reg <= ST_INIT_ERR;
                state      <= S_DONE;
              end else begin
                state <= S_DIV;
              end
            end
            ACT_START: begin
              state <= S_DONE;
              if (status_reg == ST_INIT_OK) begin
                rc_q       <= RC_OK;
                status_reg <= ST_INITIATED;
              end else begin
                rc_q <= RC_TEMP;
              end
            end
            ACT_STOP: begin
              rc_q       <= RC_OK;
              status_reg <= ST_IDLE;
              state      <= S_DONE;
            end
            ACT_VERIFY: begin
              state <= S_DONE;
              if (verify_bad) begin
                status_reg <= ST_VERIFY_ERR;
                rc_q       <= RC_TEMP;
              end else begin
                status_reg <= ST_VERIFY_OK;
                rc_q       <= RC_OK;
              end
            end
            ACT_ACTIVATE: begin
              state <= S_DONE;
              if (status_reg == ST_VERIFY_OK) begin
                status_reg <= ST_ACT_OK;
                rc_q       <= RC_OK;
              end else begin
                status_reg <= ST_ACT_ERR;
                rc_q       <= RC_TEMP;
              end
            end
            default: begin
              rc_q  <= RC_BAD_ENC;
              state <= S_DONE;
            end
          endcase
        end
        S_DIV: begin
          if (div_res.done) begin
            if (count_too_big) begin
              status_reg <= ST_INIT_ERR;
              rc_q       <= RC_BAD_ENC;
              state      <= S_DONE;
            end else begin
              // latch geometry, counts restart with the cleared bitmap
              total_blocks   <= blk_count[BLK_W-1:0];
              bitmap_len     <= bytes_sum[BM_LEN_W+2:3];
              last_block_len <= last_len_calc;
              received_count <= '0;
              first_missing  <= '0;
              clr_addr       <= '0;
              state          <= S_CLR;
            end
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BM_AW'(BITMAP_BYTES - 1)) begin
            status_reg <= ST_INIT_OK;
            rc_q       <= RC_OK;
            state      <= S_DONE;
          end
        end
        S_BCHK: begin
          // write lands this cycle, the scan fetch follows in S_SCAN
          if (!bit_hit) begin
            received_count <= received_count + 1'b1;
          end
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (first_missing >= total_blocks) begin
            first_missing <= total_blocks;
            state         <= S_DONE;
          end else begin
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          // a clear bit past the last block stops at the block total
          if (scan_found && scan_next > total_blocks) begin
            first_missing <= total_blocks;
          end else begin
            first_missing <= scan_next;
          end
          state <= scan_found ? S_DONE : S_SCAN;
        end
        S_DONE: begin
          if (!res_valid || res.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!res_valid || res.ready)) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!res_valid || res.ready)) begin
      res_rc      <= rc_q;
      res_status  <= status_reg;
      res_count   <= received_count;
      res_missing <= first_missing;
      res_bm_len  <= bitmap_len;
    end
  end

  assign cmd.ready               = (state == S_IDLE);
  assign res.valid               = res_valid;
  assign res.result_code         = res_rc;
  assign res.xfer_state          = res_status;
  assign res.blk_received        = res_count;
  assign res.first_missing_block = res_missing;
  assign res.bitmap_bytes        = res_bm_len;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    received_count <= total_blocks)
    else $error("received count above block total");

  a_missing_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_SCAN) |-> (first_missing <= total_blocks))
    else $error("first missing block above block total");

  a_ram_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLR || state == S_BCHK))
    else $error("bitmap write outside clear or block update");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == S_DIV))
    else $error("divider finished while sequencer not waiting");
`endif

endmodule

`default_nettype wire

@@ rtl/core/itbt_ram.sv @@
// ----------------------------------------------------------------------------
// itbt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module itbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/itbt_div.sv @@
// ----------------------------------------------------------------------------
// itbt_div
// Restoring divider, one quotient bit per cycle, result pulses done.
// ----------------------------------------------------------------------------
`default_nettype none

module itbt_div (
  input  logic                    clk,
  input  logic                    rst,
  input  itbt_pkg::itbt_div_req_t req,
  output itbt_pkg::itbt_div_res_t res
);
  import itbt_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DIV_W-1:0]     dsr_r;
  logic [DIV_W:0]       trial;

  // trial subtract of the shifted partial remainder
  assign trial = {rem_r, quo_r[DIV_W-1]} - {1'b0, dsr_r};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt   <= '0;
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy) begin
      cnt   <= cnt + 1'b1;
      rem_r <= trial[DIV_W] ? {rem_r[DIV_W-2:0], quo_r[DIV_W-1]} : trial[DIV_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ~trial[DIV_W]};
    end
  end

  assign res.done = done;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// image block transfer tracker testbench
// Drives commands into the tracker core over its valid/ready command channel
// and checks every report against a behavioral tracker kept alongside. A
// directed opening covers rejects, geometry limits and one full transfer.
// Random sessions follow (init, start, blocks in shuffled order with flawed
// words mixed in, verify, activate) over several block size and enable
// settings, with random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import itbt_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned IDLE_PCT      = 38;
  localparam int unsigned HOLD_AT       = 400;
  localparam int unsigned HOLD_CYCLES   = 800;
  localparam int unsigned CALM_FROM     = 600;
  localparam int unsigned CALM_TO       = 800;
  localparam int unsigned MAX_PRINTED   = 40;
  localparam int          N_PHASES      = 6;

  // action codes the block treats as malformed
  localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic               encoding_ok;
    logic [WORD_W-1:0]  blk_index;
    logic [WORD_W-1:0]  blk_len;
    logic [WORD_W-1:0]  img_size;
    logic [IDLEN_W-1:0] id_len;
  } command_t;

  typedef struct packed {
    logic [RC_W-1:0]     result_code;
    logic [STATUS_W-1:0] xfer_state;
    logic [BLK_W-1:0]    blk_received;
    logic [BLK_W-1:0]    first_missing_block;
    logic [BM_LEN_W-1:0] bitmap_bytes;
  } report_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  itbt_cmd_if cmd ();
  itbt_res_if res ();

  image_block_transfer_tracker_core dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res       (res),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // tracker state as the testbench sees it
  logic [WORD_W-1:0]     trk_blk_size;
  logic                  trk_enabled;
  logic [STATUS_W-1:0]   trk_status;
  logic [MAX_BLOCKS-1:0] trk_map;
  logic [BM_LEN_W-1:0]   trk_map_len;
  logic [BLK_W-1:0]      trk_count;
  logic [BLK_W-1:0]      trk_first_gap;
  logic [BLK_W-1:0]      trk_total;
  logic [WORD_W-1:0]     trk_last_len;

  command_t cmd_backlog[$];
  report_t  awaited_reports[$];

  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_new_blocks;
  int unsigned n_verified;
  int unsigned n_cycles;
  int unsigned hold_left;
  bit          hold_done;
  logic        calm;

  assign calm = (n_accepted >= CALM_FROM) && (n_accepted < CALM_TO);

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // next report of the tracker for one command, state updated in place
  function automatic report_t track_command(input command_t c);
    report_t           r;
    logic [RC_W-1:0]   rc;
    logic [63:0]       n_blk;
    logic [63:0]       n_bytes;
    logic [WORD_W-1:0] limit;
    logic [WORD_W-1:0] rem;
    int unsigned       b;
    rc = RC_OK;
    case (c.action)
      ACT_BLOCK: begin
        if (trk_status != ST_INIT_OK && trk_status != ST_INITIATED) begin
          rc = RC_TEMP;
        end else if (!c.encoding_ok || trk_total == 0 ||
                     c.blk_index >= 32'(trk_total)) begin
          rc = RC_BAD_ENC;
        end else begin
          limit = (c.blk_index == 32'(trk_total) - 32'd1) ? trk_last_len
                                                           : trk_blk_size;
          if (c.blk_len == 0 || c.blk_len > limit) begin
            rc = RC_BAD_ENC;
          end else begin
            if (!trk_map[c.blk_index[7:0]]) begin
              trk_map[c.blk_index[7:0]] = 1'b1;
              trk_count = trk_count + 1'b1;
              n_new_blocks++;
            end
            // lowest block still missing
            b = 0;
            while (b < 32'(trk_total) && trk_map[b]) b++;
            trk_first_gap = BLK_W'(b);
          end
        end
      end
      ACT_INIT: begin
        if (!trk_enabled) begin
          rc = RC_UNAUTH;
        end else if (!c.encoding_ok || c.id_len > MAX_ID_LEN ||
                     trk_blk_size == 0) begin
          trk_status = ST_INIT_ERR;
          rc = RC_BAD_ENC;
        end else begin
          n_blk = (64'(c.img_size) + 64'(trk_blk_size) - 64'd1) / 64'(trk_blk_size);
          n_bytes = (n_blk + 64'd7) / 64'd8;
          if (n_bytes > 64'(BITMAP_BYTES)) begin
            trk_status = ST_INIT_ERR;
            rc = RC_BAD_ENC;
          end else begin
            rem = c.img_size % trk_blk_size;
            trk_map = '0;
            trk_map_len = BM_LEN_W'(n_bytes);
            trk_total = BLK_W'(n_blk);
            trk_last_len = (n_blk == 0) ? '0 : ((rem != 0) ? rem : trk_blk_size);
            trk_count = '0;
            trk_first_gap = '0;
            trk_status = ST_INIT_OK;
          end
        end
      end
      ACT_START: begin
        if (trk_status != ST_INIT_OK) rc = RC_TEMP;
        else trk_status = ST_INITIATED;
      end
      ACT_STOP: begin
        trk_status = ST_IDLE;
      end
      ACT_VERIFY: begin
        if (trk_status != ST_INITIATED || trk_total == 0 || trk_count < trk_total ||
            trk_first_gap < trk_total) begin
          trk_status = ST_VERIFY_ERR;
          rc = RC_TEMP;
        end else begin
          trk_status = ST_VERIFY_OK;
          n_verified++;
        end
      end
      ACT_ACTIVATE: begin
        if (trk_status != ST_VERIFY_OK) begin
          trk_status = ST_ACT_ERR;
          rc = RC_TEMP;
        end else begin
          trk_status = ST_ACT_OK;
        end
      end
      default: begin
        rc = RC_BAD_ENC;
      end
    endcase
    r.result_code         = rc;
    r.xfer_state          = trk_status;
    r.blk_received        = trk_count;
    r.first_missing_block = trk_first_gap;
    r.bitmap_bytes        = trk_map_len;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      $error("report %0d field %s: expected %0d, got %0d", n_checked, name, want, got);
    end
  endtask

  task automatic queue_cmd(input logic [ACT_W-1:0] act, input logic enc,
                           input logic [WORD_W-1:0] num, input logic [WORD_W-1:0] len,
                           input logic [WORD_W-1:0] size, input logic [IDLEN_W-1:0] idlen);
    command_t c;
    c.action      = act;
    c.encoding_ok = enc;
    c.blk_index   = num;
    c.blk_len     = len;
    c.img_size    = size;
    c.id_len      = idlen;
    cmd_backlog.push_back(c);
    n_queued++;
  endtask

  // any command with random content, wide or small values
  task automatic queue_noise();
    logic [WORD_W-1:0] num;
    logic [WORD_W-1:0] len;
    logic [WORD_W-1:0] size;
    num  = ($urandom_range(1, 0) == 0) ? $urandom : $urandom_range(300, 0);
    len  = ($urandom_range(1, 0) == 0) ? $urandom : $urandom_range(600, 0);
    size = ($urandom_range(1, 0) == 0) ? $urandom : $urandom_range(20000, 0);
    queue_cmd(ACT_W'($urandom_range(7, 0)), 1'($urandom_range(1, 0)), num, len, size,
              IDLEN_W'($urandom_range(255, 0)));
  endtask

  // one image transfer: init, start, shuffled blocks with flaws, verify, activate
  task automatic queue_session(input int unsigned max_blocks);
    logic [WORD_W-1:0] bs;
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] lim;
    logic [63:0]       sz;
    int unsigned       k;
    int unsigned       j;
    int unsigned       t;
    int unsigned       b;
    int unsigned       order[$];
    bit                partial;
    bs  = (trk_blk_size == 0) ? BLOCK_SIZE_RST : trk_blk_size;
    k   = ($urandom_range(9, 0) == 0) ? $urandom_range(max_blocks, 1) : $urandom_range(16, 1);
    rem = $urandom_range(bs, 1);
    sz  = 64'(k - 1) * 64'(bs) + 64'(rem);
    if (sz > 64'hFFFF_FFFF) begin
      k  = 1;
      sz = 64'(rem);
    end
    queue_cmd(ACT_INIT, 1'b1, $urandom, $urandom, sz[31:0],
              IDLEN_W'($urandom_range(MAX_ID_LEN, 0)));
    if ($urandom_range(19, 0) != 0)
      queue_cmd(ACT_START, 1'($urandom_range(1, 0)), $urandom, $urandom, $urandom,
                IDLEN_W'($urandom_range(255, 0)));
    for (j = 0; j < k; j++) order.push_back(j);
    for (j = k; j > 1; j--) begin
      t = $urandom_range(j - 1, 0);
      b = order[j-1];
      order[j-1] = order[t];
      order[t] = b;
    end
    partial = ($urandom_range(7, 0) == 0);
    foreach (order[i]) begin
      b = order[i];
      if (partial && $urandom_range(3, 0) == 0) continue;
      lim = (b == k - 1) ? rem : bs;
      queue_cmd(ACT_BLOCK, 1'b1, b, $urandom_range(lim, 1), $urandom,
                IDLEN_W'($urandom_range(255, 0)));
      // now and then a repeated or malformed word for the same session
      if ($urandom_range(7, 0) == 0) begin
        case ($urandom_range(4, 0))
          0: queue_cmd(ACT_BLOCK, 1'b1, b, $urandom_range(lim, 1), $urandom, 8'd0);
          1: queue_cmd(ACT_BLOCK, 1'b1, b, (lim == 32'hFFFF_FFFF) ? 32'd0 : lim + 32'd1,
                       $urandom, 8'd0);
          2: queue_cmd(ACT_BLOCK, 1'b1, k + $urandom_range(3, 0), 32'd1, $urandom, 8'd0);
          3: queue_cmd(ACT_BLOCK, 1'b0, b, $urandom_range(lim, 1), $urandom, 8'd0);
          default: queue_cmd(ACT_BLOCK, 1'b1, b, 32'd0, $urandom, 8'd0);
        endcase
      end
    end
    queue_cmd(ACT_VERIFY, 1'($urandom_range(1, 0)), $urandom, $urandom, $urandom,
              IDLEN_W'($urandom_range(255, 0)));
    if ($urandom_range(3, 0) != 0)
      queue_cmd(ACT_ACTIVATE, 1'($urandom_range(1, 0)), $urandom, $urandom, $urandom,
                IDLEN_W'($urandom_range(255, 0)));
    if ($urandom_range(3, 0) == 0)
      queue_cmd(ACT_STOP, 1'($urandom_range(1, 0)), $urandom, $urandom, $urandom,
                IDLEN_W'($urandom_range(255, 0)));
  endtask

  // long sessions only while the phase budget still has room for them
  task automatic queue_random(input int unsigned n_items);
    int unsigned goal;
    int unsigned left;
    goal = n_queued + n_items;
    while (n_queued < goal) begin
      left = goal - n_queued;
      if ($urandom_range(3, 0) == 0) repeat ($urandom_range(4, 1)) queue_noise();
      else queue_session((left < MAX_BLOCKS) ? left : MAX_BLOCKS);
    end
  endtask

  // all queued words accepted and answered, then let the core settle
  task automatic wait_drained();
    while (n_accepted != n_queued || awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == REG_BLOCK_SIZE) trk_blk_size = val;
    else trk_enabled = val[0];
  endtask

  // command driver: launches the next pending word when the channel is free
  always @(posedge clk) begin : driver
    command_t c;
    if (rst) begin
      cmd.valid <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        c.action      = cmd.action;
        c.encoding_ok = cmd.encoding_ok;
        c.blk_index   = cmd.blk_index;
        c.blk_len     = cmd.blk_len;
        c.img_size    = cmd.img_size;
        c.id_len      = cmd.id_len;
        awaited_reports.push_back(track_command(c));
        n_accepted <= n_accepted + 1;
      end
      if (!cmd.valid || cmd.ready) begin
        if (cmd_backlog.size() != 0 && (calm || $urandom_range(99, 0) >= IDLE_PCT)) begin
          c = cmd_backlog.pop_front();
          cmd.valid       <= 1'b1;
          cmd.action      <= c.action;
          cmd.encoding_ok <= c.encoding_ok;
          cmd.blk_index   <= c.blk_index;
          cmd.blk_len     <= c.blk_len;
          cmd.img_size    <= c.img_size;
          cmd.id_len      <= c.id_len;
        end else begin
          cmd.valid <= 1'b0;
        end
      end
    end
  end

  // one long output stall so the core backs up into the command channel
  always @(posedge clk) begin : output_hold
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // report monitor: checks each accepted report against the oldest prediction
  always @(posedge clk) begin : monitor
    report_t want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (awaited_reports.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_PRINTED) $error("report with no command outstanding");
        end else begin
          want = awaited_reports.pop_front();
          n_checked++;
          compare_field("result_code", 32'(want.result_code), 32'(res.result_code));
          compare_field("xfer_state", 32'(want.xfer_state), 32'(res.xfer_state));
          compare_field("blk_received", 32'(want.blk_received), 32'(res.blk_received));
          compare_field("first_missing_block", 32'(want.first_missing_block),
                        32'(res.first_missing_block));
          compare_field("bitmap_bytes", 32'(want.bitmap_bytes), 32'(res.bitmap_bytes));
        end
      end
      res.ready <= (hold_left == 0) && (calm || $urandom_range(99, 0) >= IDLE_PCT);
    end
  end

  // run limit
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", n_cycles,
               awaited_reports.size());
      $display("image_block_transfer_tracker_core regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [WORD_W-1:0] ph_bs[N_PHASES];
    logic              ph_en[N_PHASES];
    int unsigned       ph_items[N_PHASES];
    int                p;

    rst             = 1'b1;
    cfg_wen         = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    cmd.valid       = 1'b0;
    cmd.action      = ACT_STOP;
    cmd.encoding_ok = 1'b0;
    cmd.blk_index   = '0;
    cmd.blk_len     = '0;
    cmd.img_size    = '0;
    cmd.id_len      = '0;
    res.ready       = 1'b0;
    n_queued = 0; n_accepted = 0; n_checked = 0; n_errors = 0;
    n_new_blocks = 0; n_verified = 0; n_cycles = 0;

    // tracker after reset
    trk_blk_size  = BLOCK_SIZE_RST;
    trk_enabled   = 1'b1;
    trk_status    = ST_IDLE;
    trk_map       = '0;
    trk_map_len   = '0;
    trk_count     = '0;
    trk_first_gap = '0;
    trk_total     = '0;
    trk_last_len  = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: rejects from idle, malformed codes, geometry limits, one transfer
    @(negedge clk);
    queue_cmd(ACT_BLOCK,    1'b1, 32'd0, 32'd1, 32'd0, 8'd0);
    queue_cmd(ACT_START,    1'b1, 32'd0, 32'd0, 32'd0, 8'd0);
    queue_cmd(ACT_VERIFY,   1'b1, 32'd0, 32'd0, 32'd0, 8'd0);
    queue_cmd(ACT_ACTIVATE, 1'b1, 32'd0, 32'd0, 32'd0, 8'd0);
    queue_cmd(ACT_SPARE6,   1'b1, 32'd0, 32'd0, 32'd0, 8'd0);
    queue_cmd(ACT_SPARE7,   1'b1, '1, '1, '1, '1);
    queue_cmd(ACT_STOP,     1'b0, 32'd0, 32'd0, 32'd0, 8'd0);
    queue_cmd(ACT_INIT,     1'b0, 32'd0, 32'd0, 32'd100, 8'd4);
    queue_cmd(ACT_INIT,     1'b1, 32'd0, 32'd0, 32'd100, 8'd33);
    // empty image: zero blocks, zero bitmap bytes
    queue_cmd(ACT_INIT,     1'b1, 32'd0, 32'd0, 32'd0, 8'd32);
    queue_cmd(ACT_START,    1'b1, 32'd0, 32'd0, 32'd0, 8'd0);
    queue_cmd(ACT_BLOCK,    1'b1, 32'd0, 32'd1, 32'd0, 8'd0);
    queue_cmd(ACT_VERIFY,   1'b1, 32'd0, 32'd0, 32'd0, 8'd0);
    // largest map that fits, one block too many, widest image size
    queue_cmd(ACT_INIT,     1'b1, 32'd0, 32'd0, 32'd12800, 8'd0);
    queue_cmd(ACT_INIT,     1'b1, 32'd0, 32'd0, 32'd12801, 8'd0);
    queue_cmd(ACT_INIT,     1'b1, 32'd0, 32'd0, '1, '1);
    // three blocks, last one a single byte
    queue_cmd(ACT_INIT,     1'b1, 32'd0, 32'd0, 32'd101, 8'd1);
    queue_cmd(ACT_BLOCK,    1'b1, 32'd0, 32'd50, 32'd0, 8'd0);
    queue_cmd(ACT_START,    1'b1, 32'd0, 32'd0, 32'd0, 8'd0);
    queue_cmd(ACT_BLOCK,    1'b1, 32'd2, 32'd2, 32'd0, 8'd0);
    queue_cmd(ACT_BLOCK,    1'b1, 32'd2, 32'd1, 32'd0, 8'd0);
    queue_cmd(ACT_BLOCK,    1'b1, 32'd1, 32'd0, 32'd0, 8'd0);
    queue_cmd(ACT_BLOCK,    1'b1, 32'd1, 32'd51, 32'd0, 8'd0);
    queue_cmd(ACT_BLOCK,    1'b1, 32'd3, 32'd1, 32'd0, 8'd0);
    queue_cmd(ACT_BLOCK,    1'b1, '1, '1, 32'd0, 8'd0);
    queue_cmd(ACT_BLOCK,    1'b0, 32'd1, 32'd50, 32'd0, 8'd0);
    queue_cmd(ACT_BLOCK,    1'b1, 32'd0, 32'd7, 32'd0, 8'd0);
    queue_cmd(ACT_BLOCK,    1'b1, 32'd1, 32'd50, 32'd0, 8'd0);
    queue_cmd(ACT_VERIFY,   1'b1, 32'd0, 32'd0, 32'd0, 8'd0);
    queue_cmd(ACT_ACTIVATE, 1'b1, 32'd0, 32'd0, 32'd0, 8'd0);
    queue_cmd(ACT_ACTIVATE, 1'b1, 32'd0, 32'd0, 32'd0, 8'd0);

    // settings: reset size, single byte, widest, zero, disabled, random
    ph_bs[0] = BLOCK_SIZE_RST;      ph_en[0] = 1'b1; ph_items[0] = 350;
    ph_bs[1] = 32'd1;               ph_en[1] = 1'b1; ph_items[1] = 250;
    ph_bs[2] = 32'hFFFF_FFFF;       ph_en[2] = 1'b1; ph_items[2] = 150;
    ph_bs[3] = 32'd0;               ph_en[3] = 1'b1; ph_items[3] = 80;
    ph_bs[4] = $urandom_range(600, 2); ph_en[4] = 1'b0; ph_items[4] = 100;
    ph_bs[5] = $urandom_range(200, 2); ph_en[5] = 1'b1; ph_items[5] = 470;

    for (p = 0; p < N_PHASES; p++) begin
      wait_drained();
      write_register(REG_BLOCK_SIZE, ph_bs[p]);
      write_register(REG_TRANSFER_ENABLED, CFG_DATA_W'(ph_en[p]));
      @(negedge clk);
      queue_random(ph_items[p]);
    end
    wait_drained();

    $display("covered %0d commands over %0d settings in %0d cycles, %0d reports checked",
             n_accepted, N_PHASES + 1, n_cycles, n_checked);
    $display("%0d new blocks recorded, %0d images verified, one %0d-cycle output stall",
             n_new_blocks, n_verified, HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("image_block_transfer_tracker_core regression: pass");
    end else begin
      $display("image_block_transfer_tracker_core regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/itbt_pkg.sv
rtl/core/itbt_if.sv
rtl/core/itbt_ram.sv
rtl/core/itbt_div.sv
rtl/core/image_block_transfer_tracker_core.sv
tb/testbench.sv
